// ----- sv/hash_chain_xor_stream_cipher_defines.svh -----
// Assertion macros used by the control module.
`ifndef HASH_CHAIN_XOR_STREAM_CIPHER_DEFINES_SVH
`define HASH_CHAIN_XOR_STREAM_CIPHER_DEFINES_SVH
// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`endif

// ----- sv/hcx_pkg.sv -----
package hcx_pkg;
  localparam int KsBytes = 32;
  localparam int Rounds = 64;

  typedef struct packed {
    logic load_key;
    logic start_hash;
    logic take;
  } hcx_cmd_t;

  typedef struct packed {
    logic hash_done;
  } hcx_stat_t;

  function automatic logic [31:0] k_const(input logic [5:0] i);
    logic [31:0] t [64];
    t = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return t[i];
  endfunction

  function automatic logic [31:0] h_init(input logic [2:0] i);
    logic [31:0] t [8];
    t = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return t[i];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage

// ----- sv/hcx_datapath.sv -----
module hcx_datapath import hcx_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  hcx_cmd_t     cmd,
  output hcx_stat_t    stat,
  input  logic [255:0] key,
  input  logic [4:0]   pos,
  input  logic [7:0]   data_byte,
  input  logic         last_byte,
  output logic [7:0]   res_byte,
  output logic         res_last
);
  logic [255:0] ks;
  logic         bypass;
  logic [31:0]  v [8];
  logic [31:0]  w [16];
  logic [6:0]   round_cnt;
  logic         busy;
  logic [31:0]  s0, s1, ch, mj, t1, t2, ws0, ws1, wnew;
  logic [7:0]   ks_sel;

  always_comb begin
    s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + s1 + ch + k_const(round_cnt[5:0]) + w[0];
    s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = s0 + mj;
    ws0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    ws1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    wnew = w[0] + ws0 + w[9] + ws1;
    ks_sel = ks[{pos, 3'b000} +: 8];
  end

  assign stat.hash_done = busy && (round_cnt == 7'(Rounds));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      round_cnt <= '0;
      ks <= '0;
      bypass <= 1'b0;
    end else begin
      if (cmd.load_key) begin
        ks <= key;
        bypass <= (key == '0);
      end
      if (cmd.start_hash) begin
        busy <= 1'b1;
        round_cnt <= '0;
        for (int i = 0; i < 8; i++) begin
          v[i] <= h_init(3'(i));
          w[i] <= {ks[32*i +: 8], ks[32*i+8 +: 8], ks[32*i+16 +: 8], ks[32*i+24 +: 8]};
        end
        w[8] <= 32'h80000000;
        for (int i = 9; i < 15; i++) w[i] <= '0;
        w[15] <= 32'd256;
      end else if (busy && round_cnt != 7'(Rounds)) begin
        v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
        v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= wnew;
        round_cnt <= round_cnt + 7'd1;
      end else if (stat.hash_done) begin
        busy <= 1'b0;
        for (int i = 0; i < 8; i++) begin
          logic [31:0] h;
          h = h_init(3'(i)) + v[i];
          ks[32*i +: 32] <= {h[7:0], h[15:8], h[23:16], h[31:24]};
        end
      end
      if (cmd.take) begin
        res_byte <= (cmd.load_key ? (key == '0) : bypass) ? data_byte :
                    data_byte ^ (cmd.load_key ? key[7:0] : ks_sel);
        res_last <= last_byte;
      end
    end
  end
endmodule

// ----- sv/hcx_ctrl.sv -----
module hcx_ctrl import hcx_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output hcx_cmd_t  cmd,
  input  hcx_stat_t stat,
  output logic [4:0] pos
);
  `include "hash_chain_xor_stream_cipher_defines.svh"
  typedef enum logic [1:0] {Run, Hash} state_t;
  state_t     state;
  logic [5:0] cnt;
  logic       msg_start;
  logic       acc;

  assign in_stall = (state != Run) || (out_valid && out_stall) || (cnt == 6'(KsBytes));
  assign acc = in_valid && !in_stall;
  assign pos = cnt[4:0];
  // The key is loaded only at the first byte of a message. A fresh digest block also
  // starts at position zero but keeps the chain going.
  always_comb begin
    cmd.take = acc;
    cmd.load_key = acc && msg_start;
    cmd.start_hash = (state == Run) && (cnt == 6'(KsBytes)) && in_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Run;
      cnt <= '0;
      msg_start <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (acc) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (acc) msg_start <= in_last;
      case (state)
        Run: begin
          if (cmd.start_hash) state <= Hash;
          else if (acc) cnt <= in_last ? 6'd0 : cnt + 6'd1;
        end
        Hash: begin
          if (stat.hash_done) begin
            state <= Run;
            cnt <= '0;
          end
        end
        default: state <= Run;
      endcase
    end
  end

  `ASSERT_SAME(a_no_acc_hash, clk, rst, state == Hash, !acc)
  `ASSERT_SAME(a_cnt_range, clk, rst, 1'b1, cnt <= 6'(KsBytes))
  `ASSERT_NEXT(a_out_after_acc, clk, rst, acc, out_valid)
endmodule

// ----- sv/hash_chain_xor_stream_cipher.sv -----
// Byte stream cipher: each accepted byte leaves XORed with the next byte of a 32-byte
// keystream block, which starts as the key and is replaced by its own SHA-256 digest after
// every 32 bytes; an all-zero key passes bytes through. An accepted byte is registered
// straight into the output register; after every 32 bytes of a message the next byte is
// stalled while the compression unit runs its 64 rounds, one round per cycle.
module hash_chain_xor_stream_cipher import hcx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last
);
  logic [63:0] key [4];
  hcx_cmd_t    cmd;
  hcx_stat_t   stat;
  logic [4:0]  pos;

  // Key registers; only four indexes exist, so the index port is exactly two bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) key[i] <= '0;
    end else if (cfg_we) begin
      key[cfg_index] <= cfg_data;
    end
  end

  hcx_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_last(last_byte), .in_stall, .out_valid, .out_stall,
    .cmd, .stat, .pos
  );

  hcx_datapath u_dp (
    .clk, .rst, .cmd, .stat, .key({key[3], key[2], key[1], key[0]}), .pos,
    .data_byte, .last_byte, .res_byte(out_byte), .res_last(out_last)
  );
endmodule
